// File: hw/rtl/clock_command_line_parser_defines.svh
// Assertion helpers shared by the parser RTL.
`ifndef CLOCK_COMMAND_LINE_PARSER_DEFINES_SVH
`define CLOCK_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define CLP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define CLP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/clp_pkg.sv
package clp_pkg;

  // Line buffer limits
  localparam int LINE_CAPACITY = 32;
  localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
  localparam int STAMP_LEN     = 19;
  localparam int PREFIX_LEN    = 4;

  // Characters
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Value limits
  localparam logic [13:0] YEAR_MIN = 14'd2000;
  localparam logic [13:0] YEAR_MAX = 14'd2099;
  localparam logic [13:0] YEAR_EPOCH = 14'd1900;
  localparam logic [6:0]  HOUR_MAX = 7'd23;
  localparam logic [6:0]  MIN_MAX  = 7'd59;
  localparam logic [6:0]  MONTH_MAX = 7'd12;

  // Keyword candidate flag bits
  localparam int FLAG_GET  = 0;
  localparam int FLAG_PING = 1;
  localparam int FLAG_SET  = 2;

  // Index of small timestamp fields; FIELD_NONE marks a separator slot
  localparam logic [2:0] FIELD_MONTH = 3'd0;
  localparam logic [2:0] FIELD_DAY   = 3'd1;
  localparam logic [2:0] FIELD_HOUR  = 3'd2;
  localparam logic [2:0] FIELD_MIN   = 3'd3;
  localparam logic [2:0] FIELD_SEC   = 3'd4;
  localparam logic [2:0] FIELD_NONE  = 3'd5;

  localparam int OUT_W  = 57;
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_GET   = 2'd0,
    KIND_PING  = 2'd1,
    KIND_SET   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BADCMD   = 3'd1,
    ERR_BADFMT   = 3'd2,
    ERR_BADVAL   = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  // Per-line scan state
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             overflow;
    logic [2:0]       flags;
    logic             shape_ok;
    logic [13:0]      year;
    logic [6:0]       month;
    logic [6:0]       day;
    logic [6:0]       hours;
    logic [6:0]       minutes;
    logic [6:0]       seconds;
  } line_st_t;

  // Empty line: every keyword still possible, stamp shape still intact
  localparam line_st_t LINE_IDLE = '{
    len:      '0,
    overflow: 1'b0,
    flags:    3'b111,
    shape_ok: 1'b1,
    year:     '0,
    month:    '0,
    day:      '0,
    hours:    '0,
    minutes:  '0,
    seconds:  '0
  };

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  weekday;
    logic [6:0]  seconds;
    logic [6:0]  minutes;
    logic [6:0]  hours;
    logic [6:0]  day_of_month;
    logic [6:0]  month;
    logic [13:0] year;
    err_t        error_code;
    kind_t       command_kind;
  } result_t;

  function automatic logic [7:0] kw_get_at(input logic [2:0] p);
    case (p)
      3'd0:    kw_get_at = 8'h54; // T
      3'd1:    kw_get_at = 8'h49; // I
      3'd2:    kw_get_at = 8'h4D; // M
      3'd3:    kw_get_at = 8'h45; // E
      3'd4:    kw_get_at = 8'h3F; // ?
      default: kw_get_at = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_ping_at(input logic [1:0] p);
    case (p)
      2'd0:    kw_ping_at = 8'h50; // P
      2'd1:    kw_ping_at = 8'h49; // I
      2'd2:    kw_ping_at = 8'h4E; // N
      default: kw_ping_at = 8'h47; // G
    endcase
  endfunction

  function automatic logic [7:0] kw_set_at(input logic [1:0] p);
    case (p)
      2'd0:    kw_set_at = 8'h53; // S
      2'd1:    kw_set_at = 8'h45; // E
      2'd2:    kw_set_at = 8'h54; // T
      default: kw_set_at = 8'h20; // space
    endcase
  endfunction

  // Which two-digit field a stamp position feeds
  function automatic logic [2:0] field_of(input logic [4:0] q);
    case (q)
      5'd5, 5'd6:   field_of = FIELD_MONTH;
      5'd8, 5'd9:   field_of = FIELD_DAY;
      5'd11, 5'd12: field_of = FIELD_HOUR;
      5'd14, 5'd15: field_of = FIELD_MIN;
      5'd17, 5'd18: field_of = FIELD_SEC;
      default:      field_of = FIELD_NONE;
    endcase
  endfunction

  // Days in month, month given as 1..12
  function automatic logic [4:0] month_days(input logic [3:0] m);
    case (m)
      4'd2:                      month_days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

  // Sakamoto month offsets, month given as 1..12
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    case (m)
      4'd1, 4'd5:  month_offset = 3'd0;
      4'd2, 4'd6:  month_offset = 3'd3;
      4'd3, 4'd11: month_offset = 3'd2;
      4'd4:        month_offset = 3'd5;
      4'd7:        month_offset = 3'd5;
      4'd8:        month_offset = 3'd1;
      4'd9:        month_offset = 3'd4;
      4'd10:       month_offset = 3'd6;
      4'd12:       month_offset = 3'd4;
      default:     month_offset = 3'd0;
    endcase
  endfunction

endpackage

// File: hw/rtl/clock_command_line_parser.sv
// Serial clock command parser. Feed one received character per input item;
// carriage returns are dropped and a newline closes the line. Each non-empty
// line yields exactly one result item: get, ping, set (with the parsed
// timestamp and ISO weekday) or an error code. Characters are taken at one
// per clock except while a newline is held; the byte passes an input register,
// updates the registered line state, and a newline moves its verdict into the
// output register. A newline is held in the input register only while a
// previous result has not been taken, and no other characters are taken meanwhile.
`include "clock_command_line_parser_defines.svh"

module clock_command_line_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] command_kind, [4:2] error_code, [18:5] year, [25:19] month,
  // [32:26] day_of_month, [39:33] hours, [46:40] minutes,
  // [53:47] seconds, [56:54] weekday, rest zero
  output logic [clp_pkg::TDATA_W-1:0]   m_axis_tdata
);
  import clp_pkg::*;

  logic     in_valid;
  logic [7:0] in_byte;
  logic     is_nl;
  logic     out_free;
  logic     proc;
  logic     emit;
  line_st_t st;
  result_t  res;
  result_t  out_res;

  // Input register handshake
  assign is_nl         = (in_byte == CHAR_LF);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign proc          = in_valid && (!is_nl || out_free);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  clp_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .take    (proc),
    .rx_byte (in_byte),
    .st      (st)
  );

  clp_judge u_judge (
    .st   (st),
    .emit (emit),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc && is_nl && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_nl && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {(TDATA_W - OUT_W)'(0), out_res};

  // Checks
  `CLP_ASSERT_NXT(a_nl_gives_item, clk, rst, proc && is_nl && emit, m_axis_tvalid,
    "judged line did not produce an item")
  `CLP_ASSERT_IMP(a_err_matches_kind, clk, rst,
    m_axis_tvalid && (out_res.command_kind != KIND_ERROR), out_res.error_code == ERR_NONE,
    "error code set on a non-error item")
  `CLP_ASSERT_IMP(a_weekday_only_on_set, clk, rst,
    m_axis_tvalid && (out_res.weekday != 3'd0), out_res.command_kind == KIND_SET,
    "weekday given outside a valid set")
  `CLP_ASSERT_IMP(a_len_bounded, clk, rst, 1'b1, st.len <= LEN_W'(LINE_CAPACITY),
    "line length beyond capacity")

endmodule

// File: hw/rtl/clp_scan.sv
module clp_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output clp_pkg::line_st_t st
);
  import clp_pkg::*;

  line_st_t st_next;

  logic [LEN_W-1:0] p;
  logic [LEN_W-1:0] q;
  logic             digit;
  logic [3:0]       d;
  logic [2:0]       fld;

  always_comb begin
    p     = st.len;
    q     = p - LEN_W'(PREFIX_LEN);
    digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    d     = digit ? 4'(rx_byte - CHAR_ZERO) : 4'd0;
    fld   = field_of(q[4:0]);
    st_next = st;
    if (take && (rx_byte != CHAR_CR)) begin
      if (rx_byte == CHAR_LF) begin
        // line judged elsewhere; back to the empty line
        st_next = LINE_IDLE;
      end else if (p == LEN_W'(LINE_CAPACITY)) begin
        st_next.overflow = 1'b1;
      end else begin
        st_next.len = p + LEN_W'(1);
        // keyword candidates
        if ((p >= LEN_W'(5)) || (rx_byte != kw_get_at(p[2:0])))
          st_next.flags[FLAG_GET] = 1'b0;
        if ((p >= LEN_W'(4)) || (rx_byte != kw_ping_at(p[1:0])))
          st_next.flags[FLAG_PING] = 1'b0;
        if (p < LEN_W'(PREFIX_LEN)) begin
          if (rx_byte != kw_set_at(p[1:0]))
            st_next.flags[FLAG_SET] = 1'b0;
        end else if (q >= LEN_W'(STAMP_LEN)) begin
          st_next.shape_ok = 1'b0;
        end else if ((q == LEN_W'(4)) || (q == LEN_W'(7))) begin
          if (rx_byte != CHAR_DASH) st_next.shape_ok = 1'b0;
        end else if (q == LEN_W'(10)) begin
          if (rx_byte != CHAR_T) st_next.shape_ok = 1'b0;
        end else if ((q == LEN_W'(13)) || (q == LEN_W'(16))) begin
          if (rx_byte != CHAR_COLON) st_next.shape_ok = 1'b0;
        end else if (!digit) begin
          st_next.shape_ok = 1'b0;
        end else if (q < LEN_W'(4)) begin
          st_next.year = (st.year << 3) + (st.year << 1) + 14'(d);
        end else begin
          // two-digit fields: times ten plus digit
          case (fld)
            FIELD_MONTH: st_next.month   = (st.month << 3) + (st.month << 1) + 7'(d);
            FIELD_DAY:   st_next.day     = (st.day << 3) + (st.day << 1) + 7'(d);
            FIELD_HOUR:  st_next.hours   = (st.hours << 3) + (st.hours << 1) + 7'(d);
            FIELD_MIN:   st_next.minutes = (st.minutes << 3) + (st.minutes << 1) + 7'(d);
            FIELD_SEC:   st_next.seconds = (st.seconds << 3) + (st.seconds << 1) + 7'(d);
            default:     st_next = st_next;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LINE_IDLE;
    end else begin
      st <= st_next;
    end
  end

endmodule

// File: hw/rtl/clp_judge.sv
module clp_judge (
  input  clp_pkg::line_st_t st,
  output logic              emit,
  output clp_pkg::result_t  res
);
  import clp_pkg::*;

  logic        stamp_ok;
  logic [4:0]  dim;
  logic [13:0] yadj;
  logic [7:0]  t;
  logic [8:0]  dsum;
  logic [4:0]  s1;
  logic [3:0]  s2;
  logic [2:0]  r;

  always_comb begin
    // calendar and clock limits; years in range make leap a 4-divisibility test
    dim = month_days(st.month[3:0]);
    if ((st.month == 7'd2) && (st.year[1:0] == 2'b00))
      dim = 5'd29;
    stamp_ok = (st.year >= YEAR_MIN) && (st.year <= YEAR_MAX)
            && (st.month >= 7'd1) && (st.month <= MONTH_MAX)
            && (st.day >= 7'd1) && (st.day <= 7'(dim))
            && (st.hours <= HOUR_MAX) && (st.minutes <= MIN_MAX)
            && (st.seconds <= MIN_MAX);

    // Sakamoto's rule with the century terms folded into a constant
    // (valid years 1999..2099 after the Jan/Feb shift)
    yadj = st.year - ((st.month < 7'd3) ? 14'd1 : 14'd0);
    t    = 8'(yadj - YEAR_EPOCH);
    dsum = 9'(t) + 9'(t[7:2]) + 9'd1 + 9'(month_offset(st.month[3:0])) + 9'(st.day);
    // mod 7 by summing octal digits (8 = 1 mod 7)
    s1 = 5'(dsum[8:6]) + 5'(dsum[5:3]) + 5'(dsum[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];

    emit = st.overflow || (st.len != '0);
    res  = '0;
    res.command_kind = KIND_ERROR;
    res.error_code   = ERR_BADCMD;
    if (st.overflow) begin
      res.error_code = ERR_OVERFLOW;
    end else if ((st.len == LEN_W'(5)) && st.flags[FLAG_GET]) begin
      res.command_kind = KIND_GET;
      res.error_code   = ERR_NONE;
    end else if ((st.len == LEN_W'(4)) && st.flags[FLAG_PING]) begin
      res.command_kind = KIND_PING;
      res.error_code   = ERR_NONE;
    end else if ((st.len >= LEN_W'(PREFIX_LEN)) && st.flags[FLAG_SET]) begin
      if ((st.len != LEN_W'(PREFIX_LEN + STAMP_LEN)) || !st.shape_ok) begin
        res.error_code = ERR_BADFMT;
      end else begin
        res.year         = st.year;
        res.month        = st.month;
        res.day_of_month = st.day;
        res.hours        = st.hours;
        res.minutes      = st.minutes;
        res.seconds      = st.seconds;
        if (stamp_ok) begin
          res.command_kind = KIND_SET;
          res.error_code   = ERR_NONE;
          res.weekday      = (r == 3'd0) ? 3'd7 : r;
        end else begin
          res.error_code = ERR_BADVAL;
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import clp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_ITEMS   = 125;
  localparam int SHOWN_ERRORS = 10;
  localparam int MAX_WAIT     = 13;
  localparam int DRAIN_CYCLES = 20;

  // Keywords, first character in the top byte
  localparam logic [39:0] GET_WORD  = "TIME?";
  localparam logic [31:0] PING_WORD = "PING";
  localparam logic [31:0] SET_WORD  = "SET ";

  localparam int DAYS_OF [12]     = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int MONTH_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;

  // Directed line with an optional hand-written verdict
  typedef struct {
    string text;
    bit    fixed;
    kind_t kind;
    err_t  err;
    int    nul_at;
  } line_case_t;

  line_case_t  line_cases[$];
  logic [7:0]  line_buf[$];
  result_t     pending_verdicts[$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  // Mirror of the per-line scan state
  int          ln_count;
  bit          ln_over;
  logic [2:0]  ln_cand;
  bit          ln_shape;
  int          ln_year;
  int          ln_fld [5];

  always #1 clk = ~clk;

  clock_command_line_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [7:0] keyword_char(int w, int p);
    case (w)
      FLAG_GET:  return GET_WORD[8*(4-p) +: 8];
      FLAG_PING: return PING_WORD[8*(3-p) +: 8];
      default:   return SET_WORD[8*(3-p) +: 8];
    endcase
  endfunction

  function automatic void clear_line_state();
    ln_count = 0;
    ln_over  = 1'b0;
    ln_cand  = 3'b111;
    ln_shape = 1'b1;
    ln_year  = 0;
    foreach (ln_fld[i]) ln_fld[i] = 0;
  endfunction

  // Fold one counted character at line position p into the scan state
  function automatic void absorb_char(int p, logic [7:0] c);
    int q;
    int f;
    bit is_digit;
    int d;
    if (p >= 5 || c != keyword_char(FLAG_GET, p)) ln_cand[FLAG_GET] = 1'b0;
    if (p >= 4 || c != keyword_char(FLAG_PING, p)) ln_cand[FLAG_PING] = 1'b0;
    if (p < PREFIX_LEN) begin
      if (c != keyword_char(FLAG_SET, p)) ln_cand[FLAG_SET] = 1'b0;
      return;
    end
    q = p - PREFIX_LEN;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d = is_digit ? int'(c - CHAR_ZERO) : 0;
    if (q >= STAMP_LEN) begin
      ln_shape = 1'b0;
    end else if (q == 4 || q == 7) begin
      if (c != CHAR_DASH) ln_shape = 1'b0;
    end else if (q == 10) begin
      if (c != CHAR_T) ln_shape = 1'b0;
    end else if (q == 13 || q == 16) begin
      if (c != CHAR_COLON) ln_shape = 1'b0;
    end else if (!is_digit) begin
      ln_shape = 1'b0;
    end else if (q < 4) begin
      ln_year = ln_year * 10 + d;
    end else begin
      // month, day, hours, minutes, seconds start at 5, 8, 11, 14, 17
      f = (q - 5) / 3;
      ln_fld[f] = ln_fld[f] * 10 + d;
    end
  endfunction

  function automatic bit stamp_in_range();
    int lim;
    bit leap;
    if (ln_year < int'(YEAR_MIN) || ln_year > int'(YEAR_MAX)) return 1'b0;
    if (ln_fld[0] < 1 || ln_fld[0] > 12) return 1'b0;
    leap = ((ln_year % 4 == 0) && (ln_year % 100 != 0)) || (ln_year % 400 == 0);
    lim = DAYS_OF[ln_fld[0] - 1];
    if (ln_fld[0] == 2 && leap) lim = 29;
    if (ln_fld[1] < 1 || ln_fld[1] > lim) return 1'b0;
    if (ln_fld[2] > int'(HOUR_MAX) || ln_fld[3] > int'(MIN_MAX) || ln_fld[4] > int'(MIN_MAX))
      return 1'b0;
    return 1'b1;
  endfunction

  // Day of week from the offset rule, 1 Monday .. 7 Sunday
  function automatic int iso_weekday_of(int y, int m, int d);
    int dow;
    if (m < 3) y = y - 1;
    dow = (y + y / 4 - y / 100 + y / 400 + MONTH_SHIFT[m - 1] + d) % 7;
    return (dow == 0) ? 7 : dow;
  endfunction

  // Advance the line model by one character; a newline may give a verdict
  function automatic void parse_char(logic [7:0] c, output bit fired, output result_t r);
    fired = 1'b0;
    r = '0;
    if (c == CHAR_CR) return;
    if (c != CHAR_LF) begin
      if (ln_count < LINE_CAPACITY) begin
        absorb_char(ln_count, c);
        ln_count++;
      end else begin
        ln_over = 1'b1;
      end
      return;
    end
    if (!ln_over && ln_count == 0) begin
      clear_line_state();
      return;
    end
    fired = 1'b1;
    if (ln_over) begin
      r.command_kind = KIND_ERROR;
      r.error_code   = ERR_OVERFLOW;
    end else if (ln_count == 5 && ln_cand[FLAG_GET]) begin
      r.command_kind = KIND_GET;
    end else if (ln_count == 4 && ln_cand[FLAG_PING]) begin
      r.command_kind = KIND_PING;
    end else if (ln_count >= PREFIX_LEN && ln_cand[FLAG_SET]) begin
      if (ln_count != PREFIX_LEN + STAMP_LEN || !ln_shape) begin
        r.command_kind = KIND_ERROR;
        r.error_code   = ERR_BADFMT;
      end else begin
        r.year         = 14'(ln_year);
        r.month        = 7'(ln_fld[0]);
        r.day_of_month = 7'(ln_fld[1]);
        r.hours        = 7'(ln_fld[2]);
        r.minutes      = 7'(ln_fld[3]);
        r.seconds      = 7'(ln_fld[4]);
        if (!stamp_in_range()) begin
          r.command_kind = KIND_ERROR;
          r.error_code   = ERR_BADVAL;
        end else begin
          r.command_kind = KIND_SET;
          r.weekday      = 3'(iso_weekday_of(ln_year, ln_fld[0], ln_fld[1]));
        end
      end
    end else begin
      r.command_kind = KIND_ERROR;
      r.error_code   = ERR_BADCMD;
    end
    clear_line_state();
  endfunction

  function automatic void add_row(string text, bit fixed = 1'b0, kind_t kind = KIND_GET,
                                  err_t err = ERR_NONE, int nul_at = -1);
    line_case_t row;
    row.text   = text;
    row.fixed  = fixed;
    row.kind   = kind;
    row.err    = err;
    row.nul_at = nul_at;
    line_cases.push_back(row);
  endfunction

  function automatic string padded(string head, int len);
    string s;
    s = head;
    while (s.len() < len) s = {s, "x"};
    return s;
  endfunction

  function automatic logic [7:0] non_lf_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
    return b;
  endfunction

  function automatic void push_number(int v, int n);
    int div;
    div = 1;
    for (int k = 1; k < n; k++) div = div * 10;
    while (div > 0) begin
      line_buf.push_back(8'(int'(CHAR_ZERO) + (v / div) % 10));
      div = div / 10;
    end
  endfunction

  // One random line: mostly timestamps, then keywords, noise and long lines
  function automatic void make_random_line();
    int pick;
    int w;
    int n;
    pick = $urandom_range(0, 99);
    line_buf.delete();
    if (pick < 55) begin
      for (int k = 0; k < 4; k++) line_buf.push_back(keyword_char(FLAG_SET, k));
      push_number(($urandom_range(0, 9) < 7) ? $urandom_range(2000, 2099)
                                             : $urandom_range(0, 9999), 4);
      line_buf.push_back(CHAR_DASH);
      push_number(($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 99), 2);
      line_buf.push_back(CHAR_DASH);
      n = $urandom_range(0, 9);
      push_number((n < 6) ? $urandom_range(1, 28) :
                  (n < 8) ? $urandom_range(29, 31) : $urandom_range(0, 99), 2);
      line_buf.push_back(CHAR_T);
      push_number(($urandom_range(0, 9) < 8) ? $urandom_range(0, 23) : $urandom_range(0, 99), 2);
      line_buf.push_back(CHAR_COLON);
      push_number(($urandom_range(0, 19) < 17) ? $urandom_range(0, 59) : $urandom_range(0, 99), 2);
      line_buf.push_back(CHAR_COLON);
      push_number(($urandom_range(0, 19) < 17) ? $urandom_range(0, 59) : $urandom_range(0, 99), 2);
      if ($urandom_range(0, 6) == 0)
        line_buf[$urandom_range(0, line_buf.size() - 1)] = non_lf_byte();
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) void'(line_buf.pop_back());
        else line_buf.push_back(8'(int'(CHAR_ZERO) + $urandom_range(0, 9)));
      end
    end else if (pick < 65) begin
      w = ($urandom_range(0, 1) == 0) ? FLAG_GET : FLAG_PING;
      n = (w == FLAG_GET) ? 5 : 4;
      for (int k = 0; k < n; k++) line_buf.push_back(keyword_char(w, k));
      if ($urandom_range(0, 4) == 0) line_buf[$urandom_range(0, n - 1)] = non_lf_byte();
    end else if (pick < 78) begin
      n = $urandom_range(1, 10);
      repeat (n) line_buf.push_back(non_lf_byte());
    end else if (pick < 88) begin
      n = $urandom_range(28, 45);
      repeat (n) line_buf.push_back(non_lf_byte());
    end else begin
      // keyword fragments, possibly with trailing junk
      w = $urandom_range(0, 2);
      n = $urandom_range(0, (w == FLAG_GET) ? 5 : 4);
      for (int k = 0; k < n; k++) line_buf.push_back(keyword_char(w, k));
      repeat ($urandom_range(0, 2)) line_buf.push_back(non_lf_byte());
    end
    if ($urandom_range(0, 7) == 0)
      line_buf.insert($urandom_range(0, line_buf.size()), CHAR_CR);
    line_buf.push_back(CHAR_LF);
  endfunction

  // Present one character; called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input bit fixed, input result_t fixed_r);
    int gap;
    bit fired;
    result_t r;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    parse_char(c, fired, r);
    if (fired) pending_verdicts.push_back(fixed ? fixed_r : r);
    @(negedge clk);
  endtask

  task automatic send_line(input bit fixed, input result_t fixed_r);
    steady = ($urandom_range(0, 4) == 0);
    foreach (line_buf[k]) send_char(line_buf[k], fixed, fixed_r);
  endtask

  task automatic compare_field(string name, logic [13:0] want, logic [13:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("mismatch in %s: expected %0d, got %0d", name, want, seen);
    end
  endtask

  task automatic check_verdict(result_t seen);
    result_t want;
    if (pending_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("result item with none pending: kind %0d, error %0d",
                 seen.command_kind, seen.error_code);
      return;
    end
    want = pending_verdicts.pop_front();
    compare_field("command_kind", want.command_kind, seen.command_kind);
    compare_field("error_code", want.error_code, seen.error_code);
    compare_field("year", want.year, seen.year);
    compare_field("month", want.month, seen.month);
    compare_field("day_of_month", want.day_of_month, seen.day_of_month);
    compare_field("hours", want.hours, seen.hours);
    compare_field("minutes", want.minutes, seen.minutes);
    compare_field("seconds", want.seconds, seen.seconds);
    compare_field("weekday", want.weekday, seen.weekday);
  endtask

  // Result side: random stall before each item, then take it
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (m_axis_tvalid !== 1'b1 || rst) @(posedge clk);
      check_verdict(result_t'(m_axis_tdata[OUT_W-1:0]));
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Character side: directed lines, then random lines
  initial begin
    result_t fixed_r;
    int rand_sent;
    clear_line_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // "\015" is a carriage return
    add_row("TIME?\n", 1, KIND_GET, ERR_NONE);
    add_row("PING\n", 1, KIND_PING, ERR_NONE);
    add_row("\n");
    add_row("\015\015\n");
    add_row("P\015ING\015\n", 1, KIND_PING, ERR_NONE);
    add_row("SET 2024-02-29T23:59:59\n");
    add_row("SET 2000-01-01T00:00:00\n");
    add_row("SET 2099-12-31T23:59:59\n");
    add_row("SET 2100-02-29T00:00:00\n");
    add_row("SET 1999-12-31T23:59:59\n");
    add_row("SET 2023-02-29T12:30:45\n");
    add_row("SET 2024-00-10T10:10:10\n");
    add_row("SET 2024-04-31T24:60:60\n");
    add_row("SET 9999-99-99T99:99:99\n");
    add_row("SET 2024-06-15 12:00:00\n", 1, KIND_ERROR, ERR_BADFMT);
    add_row("SET 2024-06-15T12:00:0\n", 1, KIND_ERROR, ERR_BADFMT);
    add_row("SET 2024-06-15T12:00:00Z\n", 1, KIND_ERROR, ERR_BADFMT);
    add_row("SET \n", 1, KIND_ERROR, ERR_BADFMT);
    add_row("SETX2024-06-15T12:00:00\n", 1, KIND_ERROR, ERR_BADCMD);
    add_row("TIME?X\n", 1, KIND_ERROR, ERR_BADCMD);
    add_row("time?\n", 1, KIND_ERROR, ERR_BADCMD);
    add_row("A?CD\n", 1, KIND_ERROR, ERR_BADCMD, 1);
    add_row("\377\200\n", 1, KIND_ERROR, ERR_BADCMD);
    add_row({padded("SET ", LINE_CAPACITY), "\n"}, 1, KIND_ERROR, ERR_BADFMT);
    add_row({padded("PING", LINE_CAPACITY + 1), "\015\n"}, 1, KIND_ERROR, ERR_OVERFLOW);

    foreach (line_cases[i]) begin
      fixed_r = '0;
      fixed_r.command_kind = line_cases[i].kind;
      fixed_r.error_code   = line_cases[i].err;
      line_buf.delete();
      for (int k = 0; k < line_cases[i].text.len(); k++)
        line_buf.push_back((k == line_cases[i].nul_at) ? 8'h00 : line_cases[i].text[k]);
      send_line(line_cases[i].fixed, fixed_r);
    end

    fixed_r = '0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      make_random_line();
      foreach (line_buf[k]) if (line_buf[k] != CHAR_CR) rand_sent++;
      send_line(1'b0, fixed_r);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
